/* src/gdda_pkg.sv */
// ----------------------------------------------------------------------------
// gdda_pkg
// Types and constants shared by the grid DDA ray caster modules.
// ----------------------------------------------------------------------------
package gdda_pkg;

	localparam int DIR_FRAC = 14;
	localparam int DIST_W = 17;
	localparam logic [DIST_W-1:0] DIST_MAX = 17'h1FFFF;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_CAST  = 1'b1
	} op_t;

	typedef struct packed {
		logic               op;
		logic [5:0]         cell_x;
		logic [5:0]         cell_y;
		logic               cell_wall;
		logic [15:0]        origin_x;
		logic [15:0]        origin_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
	} request_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              hit_side;
		logic [5:0]        hit_x;
		logic [5:0]        hit_y;
		logic              escaped;
	} result_t;

	typedef enum logic [1:0] {
		EMIT_NONE   = 2'd0,
		EMIT_ORIGIN = 2'd1,
		EMIT_HIT    = 2'd2,
		EMIT_ESC    = 2'd3
	} emit_t;

	typedef struct packed {
		logic  clear;
		logic  write;
		logic  load;
		logic  div;
		logic  mul_x;
		logic  mul_y;
		logic  advance;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic div_last;
		logic origin_out;
		logic wall_hit;
		logic leaving;
	} status_t;

endpackage

/* src/gdda_ram.sv */
// ----------------------------------------------------------------------------
// gdda_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module gdda_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

/* src/gdda_ctrl.sv */
// ----------------------------------------------------------------------------
// gdda_ctrl
// Sequencer for map clearing, cell writes, divisions, multiplies and DDA steps.
// ----------------------------------------------------------------------------
module gdda_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             op,
	input  gdda_pkg::status_t st,
	output gdda_pkg::cmd_t   cmd,
	output logic             busy
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_MULX,
		ST_MULY,
		ST_STEP
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	always_comb begin
		cmd = '0;
		cmd.emit = gdda_pkg::EMIT_NONE;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (st.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (op == gdda_pkg::OP_CAST) begin
						cmd.load = 1'b1;
						state_d = ST_DIV;
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			ST_DIV: begin
				if (st.origin_out) begin
					cmd.emit = gdda_pkg::EMIT_ORIGIN;
					state_d = ST_IDLE;
				end else begin
					cmd.div = 1'b1;
					if (st.div_last) begin
						state_d = ST_MULX;
					end
				end
			end
			ST_MULX: begin
				cmd.mul_x = 1'b1;
				state_d = ST_MULY;
			end
			ST_MULY: begin
				cmd.mul_y = 1'b1;
				state_d = ST_STEP;
			end
			ST_STEP: begin
				if (st.wall_hit) begin
					cmd.emit = gdda_pkg::EMIT_HIT;
					state_d = ST_IDLE;
				end else if (st.leaving) begin
					cmd.emit = gdda_pkg::EMIT_ESC;
					state_d = ST_IDLE;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			busy_q <= 1'b1;
		end else begin
			state_q <= state_d;
			busy_q <= (state_d != ST_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

/* src/gdda_datapath.sv */
// ----------------------------------------------------------------------------
// gdda_datapath
// Wall map, reciprocal dividers, side distance multiplier and DDA step logic.
// ----------------------------------------------------------------------------
module gdda_datapath #(
	parameter int MAP_WIDTH = 64,
	parameter int MAP_HEIGHT = 64,
	parameter int FRAC_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gdda_pkg::request_t request,
	input  gdda_pkg::cmd_t     cmd,
	output gdda_pkg::status_t  st,
	output logic               done,
	output gdda_pkg::result_t  result
);

	localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int XIW = $clog2(MAP_WIDTH);
	localparam int YIW = $clog2(MAP_HEIGHT);
	localparam int CXW = $clog2(MAP_WIDTH) + 2;
	localparam int CYW = $clog2(MAP_HEIGHT) + 2;
	localparam int QW = gdda_pkg::DIR_FRAC + 1 + FRAC_BITS;
	localparam int DW = QW + 1;
	localparam int CNTW = $clog2(QW);
	localparam int SW = DW + $clog2(MAP_WIDTH + MAP_HEIGHT) + 2;
	localparam int PW = FRAC_BITS + 1;
	localparam logic [DW-1:0] DELTA_MAX = DW'(1) << QW;
	localparam logic [PW-1:0] FIX_ONE = PW'(1) << FRAC_BITS;

	logic [15:0]           ox_q, oy_q;
	logic                  neg_x_q, neg_y_q;
	logic [15:0]           mag_x_q, mag_y_q;
	logic [16:0]           rem_x_q, rem_y_q;
	logic [QW-1:0]         quo_x_q, quo_y_q;
	logic [CNTW-1:0]       cnt_q;
	logic [AW-1:0]         clr_cnt_q;
	logic [SW-1:0]         side_x_q, side_y_q, dist_q;
	logic                  side_q;
	logic signed [CXW-1:0] cx_q;
	logic signed [CYW-1:0] cy_q;
	logic                  rd_pend_q;
	logic                  done_q;
	gdda_pkg::result_t     result_q;

	logic [15:0]           mag_x_in, mag_y_in;
	logic                  dbit;
	logic [16:0]           rs_x, rs_y;
	logic                  ge_x, ge_y;
	logic [DW-1:0]         delta_x, delta_y;
	logic [PW-1:0]         part_x, part_y, mul_a;
	logic [DW-1:0]         mul_b;
	logic [PW+DW-1:0]      prod;
	logic                  take_x;
	logic [SW-1:0]         nx_dist;
	logic signed [CXW-1:0] cx_n;
	logic signed [CYW-1:0] cy_n;
	logic                  wr_in_map;
	logic [AW-1:0]         ray_addr, wr_addr, ram_addr;
	logic                  ram_we;
	logic [0:0]            ram_wdata, ram_rdata;
	logic [SW-1:0]         emit_dist;

	assign mag_x_in = request.dir_x[15] ? 16'(-request.dir_x) : 16'(request.dir_x);
	assign mag_y_in = request.dir_y[15] ? 16'(-request.dir_y) : 16'(request.dir_y);

	assign dbit = (cnt_q == '0);
	assign rs_x = {rem_x_q[15:0], dbit};
	assign rs_y = {rem_y_q[15:0], dbit};
	assign ge_x = (rs_x >= {1'b0, mag_x_q});
	assign ge_y = (rs_y >= {1'b0, mag_y_q});

	assign delta_x = (mag_x_q == '0) ? DELTA_MAX : DW'(quo_x_q);
	assign delta_y = (mag_y_q == '0) ? DELTA_MAX : DW'(quo_y_q);

	assign part_x = neg_x_q ? PW'(ox_q[FRAC_BITS-1:0]) : FIX_ONE - PW'(ox_q[FRAC_BITS-1:0]);
	assign part_y = neg_y_q ? PW'(oy_q[FRAC_BITS-1:0]) : FIX_ONE - PW'(oy_q[FRAC_BITS-1:0]);
	assign mul_a = cmd.mul_y ? part_y : part_x;
	assign mul_b = cmd.mul_y ? delta_y : delta_x;
	assign prod = (PW+DW)'(mul_a) * (PW+DW)'(mul_b);

	assign take_x = (side_x_q < side_y_q);
	assign nx_dist = take_x ? side_x_q : side_y_q;
	assign cx_n = take_x ? (neg_x_q ? cx_q - CXW'(1) : cx_q + CXW'(1)) : cx_q;
	assign cy_n = take_x ? cy_q : (neg_y_q ? cy_q - CYW'(1) : cy_q + CYW'(1));

	assign ray_addr = AW'(int'(cy_n[YIW-1:0]) * MAP_WIDTH) + AW'(cx_n[XIW-1:0]);
	assign wr_in_map = (32'(request.cell_x) < MAP_WIDTH) && (32'(request.cell_y) < MAP_HEIGHT);
	assign wr_addr = AW'(int'(request.cell_y) * MAP_WIDTH + int'(request.cell_x));

	always_comb begin
		if (cmd.clear) begin
			ram_addr = clr_cnt_q;
		end else if (cmd.write) begin
			ram_addr = wr_addr;
		end else begin
			ram_addr = ray_addr;
		end
	end
	assign ram_we = cmd.clear || (cmd.write && wr_in_map);
	assign ram_wdata = cmd.clear ? 1'b0 : request.cell_wall;

	gdda_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign st.clear_last = (clr_cnt_q == AW'(DEPTH - 1));
	assign st.div_last = (cnt_q == CNTW'(QW - 1));
	assign st.origin_out = (32'(ox_q[15:FRAC_BITS]) >= MAP_WIDTH) ||
		(32'(oy_q[15:FRAC_BITS]) >= MAP_HEIGHT);
	assign st.wall_hit = rd_pend_q && ram_rdata[0];
	assign st.leaving = cx_n[CXW-1] || (cx_n >= $signed(CXW'(MAP_WIDTH))) ||
		cy_n[CYW-1] || (cy_n >= $signed(CYW'(MAP_HEIGHT)));

	assign emit_dist = (cmd.emit == gdda_pkg::EMIT_ESC) ? nx_dist : dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			cnt_q <= '0;
			rd_pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.div) begin
				cnt_q <= cnt_q + CNTW'(1);
			end
			rd_pend_q <= cmd.advance;
			done_q <= (cmd.emit != gdda_pkg::EMIT_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ox_q <= request.origin_x;
			oy_q <= request.origin_y;
			neg_x_q <= request.dir_x[15];
			neg_y_q <= request.dir_y[15];
			mag_x_q <= mag_x_in;
			mag_y_q <= mag_y_in;
			rem_x_q <= '0;
			rem_y_q <= '0;
			quo_x_q <= '0;
			quo_y_q <= '0;
			cx_q <= CXW'(request.origin_x[15:FRAC_BITS]);
			cy_q <= CYW'(request.origin_y[15:FRAC_BITS]);
			side_q <= 1'b0;
			dist_q <= '0;
		end
		if (cmd.div) begin
			rem_x_q <= ge_x ? rs_x - {1'b0, mag_x_q} : rs_x;
			rem_y_q <= ge_y ? rs_y - {1'b0, mag_y_q} : rs_y;
			quo_x_q <= {quo_x_q[QW-2:0], ge_x};
			quo_y_q <= {quo_y_q[QW-2:0], ge_y};
		end
		if (cmd.mul_x) begin
			side_x_q <= SW'(prod >> FRAC_BITS);
		end
		if (cmd.mul_y) begin
			side_y_q <= SW'(prod >> FRAC_BITS);
		end
		if (cmd.advance) begin
			dist_q <= nx_dist;
			side_q <= !take_x;
			cx_q <= cx_n;
			cy_q <= cy_n;
			if (take_x) begin
				side_x_q <= side_x_q + SW'(delta_x);
			end else begin
				side_y_q <= side_y_q + SW'(delta_y);
			end
		end
		case (cmd.emit)
			gdda_pkg::EMIT_ORIGIN: begin
				result_q.distance <= '0;
				result_q.hit_side <= 1'b0;
				result_q.hit_x <= '0;
				result_q.hit_y <= '0;
				result_q.escaped <= 1'b1;
			end
			gdda_pkg::EMIT_HIT: begin
				result_q.distance <= (emit_dist > SW'(gdda_pkg::DIST_MAX)) ?
					gdda_pkg::DIST_MAX : emit_dist[gdda_pkg::DIST_W-1:0];
				result_q.hit_side <= side_q;
				result_q.hit_x <= 6'($unsigned(cx_q));
				result_q.hit_y <= 6'($unsigned(cy_q));
				result_q.escaped <= 1'b0;
			end
			gdda_pkg::EMIT_ESC: begin
				result_q.distance <= (emit_dist > SW'(gdda_pkg::DIST_MAX)) ?
					gdda_pkg::DIST_MAX : emit_dist[gdda_pkg::DIST_W-1:0];
				result_q.hit_side <= !take_x;
				result_q.hit_x <= '0;
				result_q.hit_y <= '0;
				result_q.escaped <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign result = result_q;

endmodule

/* src/grid_dda_ray_caster.sv */
// ----------------------------------------------------------------------------
// grid_dda_ray_caster
// Grid DDA ray caster over a one-bit wall map held in on-chip RAM.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low.
// A write request (op 0) updates one map cell in that same cycle and gives no
// result; busy stays low, so writes can be issued every cycle.
// A cast request (op 1) runs two bit-serial reciprocal divisions in parallel,
// then uses the shared multiplier for the first side distances, then runs
// the DDA steps, each reading one map cell.
// The result appears on result with done high for exactly one cycle.
// An origin outside the map is caught in the first division state, and its
// result is registered from there. The receiver cannot stall; the result
// register holds only until the next result. After reset the map is cleared,
// all MAP_WIDTH*MAP_HEIGHT cells (4096 by default), while busy stays high.
// ----------------------------------------------------------------------------
module grid_dda_ray_caster #(
	parameter int MAP_WIDTH = 64,
	parameter int MAP_HEIGHT = 64,
	parameter int FRAC_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  gdda_pkg::request_t request,
	output logic               done,
	output gdda_pkg::result_t  result
);

	gdda_pkg::cmd_t    cmd;
	gdda_pkg::status_t st;

	gdda_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.op    (request.op),
		.st    (st),
		.cmd   (cmd),
		.busy  (busy)
	);

	gdda_datapath #(
		.MAP_WIDTH (MAP_WIDTH),
		.MAP_HEIGHT(MAP_HEIGHT),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.cmd    (cmd),
		.st     (st),
		.done   (done),
		.result (result)
	);

endmodule

/* src/gdda_checker.sv */
// ----------------------------------------------------------------------------
// gdda_checker
// Port-level checks of the ray caster's request and result timing.
// ----------------------------------------------------------------------------
module gdda_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input gdda_pkg::request_t request,
	input logic               done
);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result strobe lasted more than one cycle.");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result delivered while busy.");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.op == gdda_pkg::OP_WRITE) |=> (!busy && !done))
		else $error("A write request made the block busy or gave a result.");

	a_cast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.op == gdda_pkg::OP_CAST) |=> (busy && !done))
		else $error("A cast request did not make the block busy.");

endmodule

bind grid_dda_ray_caster gdda_checker u_gdda_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.request(request),
	.done   (done)
);
